// ===== src/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define BBA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked assertion that also runs during reset.
`define BBA_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/bba_pkg.sv =====
package bba_pkg;

  localparam int BLK_W     = 16;
  localparam int CNT_W     = 17;
  localparam int FIELD_CAP = 65536;
  localparam int SUM_W     = 32;
  localparam int SUM_LOG   = 5;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    FN_INIT  = 2'd0,
    FN_ALLOC = 2'd1,
    FN_FREE  = 2'd2,
    FN_TEST  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOTAL    = 2'd0,
    REG_RESERVED = 2'd1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_DIV,
    S_REM,
    S_RD,
    S_MOD,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_ARD,
    S_AFIND,
    S_AWR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [CNT_W-1:0] managed;
    logic [CNT_W-1:0] reserved;
  } size_t;

  typedef struct packed {
    logic [BLK_W-1:0] granted_block;
    logic             bit_value;
    status_t          status;
    logic [CNT_W-1:0] free_count;
  } res_t;

endpackage

// ===== src/bba_ram.sv =====
module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/bba_ctrl.sv =====
module bba_ctrl #(
  parameter int MAX_BLOCKS    = 65536,
  parameter int MAP_WORD_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_func,
  input  logic [bba_pkg::BLK_W-1:0] in_block,
  input  bba_pkg::size_t            size,
  output logic                      res_valid,
  input  logic                      res_ready,
  output bba_pkg::res_t             res
);

  localparam int NUM_WORDS = (MAX_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int W_W       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int SUM_DEPTH = (NUM_WORDS + bba_pkg::SUM_W - 1) / bba_pkg::SUM_W;
  localparam int SA_W      = (SUM_DEPTH > 1) ? $clog2(SUM_DEPTH) : 1;
  localparam int WX_W      = SA_W + bba_pkg::SUM_LOG;
  localparam int BP_W      = $clog2(MAP_WORD_BITS);
  localparam int BASE_W    = $clog2(NUM_WORDS * MAP_WORD_BITS + 1) + 1;
  localparam int CW        = ((BASE_W > bba_pkg::CNT_W) ? BASE_W : bba_pkg::CNT_W) + 1;
  localparam int SH_W      = $clog2(MAP_WORD_BITS + 1);
  localparam int DIV_S     = bba_pkg::BLK_W + BP_W;
  localparam int RC_W      = 18;
  localparam int Q_W       = 17;
  localparam int PROD_W    = DIV_S + Q_W;
  localparam int RM_W      = Q_W + 8;
  localparam int RECIP     = ((1 << DIV_S) + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int CNT_W     = bba_pkg::CNT_W;
  localparam int BLK_W     = bba_pkg::BLK_W;
  localparam int SUM_W     = bba_pkg::SUM_W;
  localparam int SUM_LOG   = bba_pkg::SUM_LOG;

  localparam logic [RC_W-1:0]          RECIP_V = RC_W'(RECIP);
  localparam logic [MAP_WORD_BITS-1:0] M_ONES  = '1;
  localparam logic [SUM_W-1:0]         S_ONES  = '1;
  localparam logic [W_W-1:0]           W_LAST  = W_W'(NUM_WORDS - 1);
  localparam logic [SA_W-1:0]          S_LAST  = SA_W'(SUM_DEPTH - 1);

  bba_pkg::state_t state_r, state_nxt;

  logic                     clr_r, clr_nxt;
  logic [W_W-1:0]           wcnt_r, wcnt_nxt;
  logic [BASE_W-1:0]        base_r, base_nxt;
  logic [CNT_W-1:0]         rinit_r, rinit_nxt;
  logic [SUM_W-1:0]         sacc_r, sacc_nxt;
  logic [SA_W-1:0]          sidx_r, sidx_nxt;
  logic [CNT_W-1:0]         free_r, free_nxt;

  bba_pkg::func_t           fn_r, fn_nxt;
  logic [BLK_W-1:0]         blk_r, blk_nxt;
  logic [W_W-1:0]           word_r, word_nxt;
  logic [BP_W-1:0]          bpos_r, bpos_nxt;
  logic [PROD_W-1:0]        prod_r, prod_nxt;
  logic [BLK_W-1:0]         gr_r, gr_nxt;
  logic                     bit_r, bit_nxt;
  bba_pkg::status_t         st_r, st_nxt;

  logic                     m_we, m_re;
  logic [W_W-1:0]           m_waddr, m_raddr;
  logic [MAP_WORD_BITS-1:0] m_wdata, m_rdata;
  logic                     s_we, s_re;
  logic [SA_W-1:0]          s_waddr, s_raddr;
  logic [SUM_W-1:0]         s_wdata, s_rdata;

  logic [BP_W-1:0]          mz_idx;
  logic [SUM_LOG-1:0]       sz_idx;
  logic [WX_W-1:0]          wx_word, wx_cnt;
  logic [Q_W-1:0]           quot;
  logic [RM_W-1:0]          rem_full;
  logic [CW-1:0]            base_c, rinit_c, diff_c, sh_c, b_c;
  logic                     full_w, empty_w, last_w;
  logic [MAP_WORD_BITS-1:0] init_word, m_bit, m_set;
  logic [SUM_W-1:0]         sval, s_bit;

  bba_ram #(.WIDTH(MAP_WORD_BITS), .DEPTH(NUM_WORDS), .AW(W_W)) u_map (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .re    (m_re),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  bba_ram #(.WIDTH(SUM_W), .DEPTH(SUM_DEPTH), .AW(SA_W)) u_sum (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  // lowest clear bit of the map word and of the summary word
  always_comb begin
    mz_idx = '0;
    for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
      if (!m_rdata[i]) mz_idx = BP_W'(i);
    end
  end

  always_comb begin
    sz_idx = '0;
    for (int i = SUM_W - 1; i >= 0; i--) begin
      if (!s_rdata[i]) sz_idx = SUM_LOG'(i);
    end
  end

  assign wx_word  = WX_W'(word_r);
  assign wx_cnt   = WX_W'(wcnt_r);
  assign quot     = prod_r[DIV_S +: Q_W];
  assign rem_full = RM_W'(blk_r) - RM_W'(quot) * RM_W'(MAP_WORD_BITS);
  assign m_bit    = MAP_WORD_BITS'(1) << bpos_r;
  assign m_set    = m_rdata | m_bit;
  assign s_bit    = SUM_W'(1) << wx_word[SUM_LOG-1:0];

  // init sweep: word contents for the reserved prefix
  assign base_c   = CW'(base_r);
  assign rinit_c  = CW'(rinit_r);
  assign diff_c   = rinit_c - base_c;
  assign sh_c     = CW'(MAP_WORD_BITS) - diff_c;
  assign full_w   = (base_c + CW'(MAP_WORD_BITS)) <= rinit_c;
  assign empty_w  = base_c >= rinit_c;
  assign last_w   = (wcnt_r == W_LAST);
  assign b_c      = CW'(base_r) + CW'(bpos_r);

  always_comb begin
    if (full_w) begin
      init_word = M_ONES;
    end else if (empty_w) begin
      init_word = '0;
    end else begin
      init_word = M_ONES >> sh_c[SH_W-1:0];
    end
  end

  assign sval = full_w ? sacc_r : (sacc_r & ~(SUM_W'(1) << wx_cnt[SUM_LOG-1:0]));

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    wcnt_nxt  = wcnt_r;
    base_nxt  = base_r;
    rinit_nxt = rinit_r;
    sacc_nxt  = sacc_r;
    sidx_nxt  = sidx_r;
    free_nxt  = free_r;
    fn_nxt    = fn_r;
    blk_nxt   = blk_r;
    word_nxt  = word_r;
    bpos_nxt  = bpos_r;
    prod_nxt  = prod_r;
    gr_nxt    = gr_r;
    bit_nxt   = bit_r;
    st_nxt    = st_r;
    m_we      = 1'b0;
    m_waddr   = word_r;
    m_wdata   = m_rdata;
    m_re      = 1'b0;
    m_raddr   = word_r;
    s_we      = 1'b0;
    s_waddr   = wx_word[WX_W-1:SUM_LOG];
    s_wdata   = s_rdata;
    s_re      = 1'b0;
    s_raddr   = wx_word[WX_W-1:SUM_LOG];
    in_ready  = 1'b0;
    res_valid = 1'b0;

    case (state_r)
      bba_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          fn_nxt  = bba_pkg::func_t'(in_func);
          blk_nxt = in_block;
          gr_nxt  = '0;
          bit_nxt = 1'b0;
          st_nxt  = bba_pkg::ST_OK;
          case (bba_pkg::func_t'(in_func))
            bba_pkg::FN_INIT: begin
              clr_nxt   = 1'b0;
              wcnt_nxt  = '0;
              base_nxt  = '0;
              sacc_nxt  = S_ONES;
              rinit_nxt = size.reserved;
              free_nxt  = size.managed - size.reserved;
              state_nxt = bba_pkg::S_INIT;
            end
            bba_pkg::FN_ALLOC: begin
              sidx_nxt = '0;
              if (free_r == '0) begin
                st_nxt    = bba_pkg::ST_NOSPACE;
                state_nxt = bba_pkg::S_DONE;
              end else begin
                state_nxt = bba_pkg::S_SCAN_RD;
              end
            end
            bba_pkg::FN_FREE, bba_pkg::FN_TEST: begin
              gr_nxt = in_block;
              if ({1'b0, in_block} >= size.managed) begin
                st_nxt    = bba_pkg::ST_RANGE;
                state_nxt = bba_pkg::S_DONE;
              end else begin
                state_nxt = bba_pkg::S_DIV;
              end
            end
            default: state_nxt = bba_pkg::S_IDLE;
          endcase
        end
      end

      bba_pkg::S_INIT: begin
        m_we     = 1'b1;
        m_waddr  = wcnt_r;
        m_wdata  = init_word;
        s_waddr  = wx_cnt[WX_W-1:SUM_LOG];
        s_wdata  = sval;
        wcnt_nxt = wcnt_r + W_W'(1);
        base_nxt = base_r + BASE_W'(MAP_WORD_BITS);
        if (wx_cnt[SUM_LOG-1:0] == SUM_LOG'(SUM_W - 1) || last_w) begin
          s_we     = 1'b1;
          sacc_nxt = S_ONES;
        end else begin
          sacc_nxt = sval;
        end
        if (last_w) begin
          clr_nxt   = 1'b0;
          state_nxt = clr_r ? bba_pkg::S_IDLE : bba_pkg::S_DONE;
        end
      end

      bba_pkg::S_DIV: begin
        prod_nxt  = PROD_W'(blk_r) * PROD_W'(RECIP_V);
        state_nxt = bba_pkg::S_REM;
      end

      bba_pkg::S_REM: begin
        word_nxt  = quot[W_W-1:0];
        bpos_nxt  = rem_full[BP_W-1:0];
        state_nxt = bba_pkg::S_RD;
      end

      bba_pkg::S_RD: begin
        m_re      = 1'b1;
        s_re      = 1'b1;
        state_nxt = bba_pkg::S_MOD;
      end

      bba_pkg::S_MOD: begin
        if (fn_r == bba_pkg::FN_FREE) begin
          m_we    = 1'b1;
          m_wdata = m_rdata & ~m_bit;
          s_we    = 1'b1;
          s_wdata = s_rdata & ~s_bit;
          if (free_r < size.managed) free_nxt = free_r + CNT_W'(1);
        end else begin
          bit_nxt = m_rdata[bpos_r];
        end
        state_nxt = bba_pkg::S_DONE;
      end

      bba_pkg::S_SCAN_RD: begin
        s_re      = 1'b1;
        s_raddr   = sidx_r;
        state_nxt = bba_pkg::S_SCAN_CHK;
      end

      bba_pkg::S_SCAN_CHK: begin
        if (s_rdata != S_ONES) begin
          word_nxt  = W_W'({sidx_r, sz_idx});
          state_nxt = bba_pkg::S_ARD;
        end else if (sidx_r == S_LAST) begin
          st_nxt    = bba_pkg::ST_NOSPACE;
          state_nxt = bba_pkg::S_DONE;
        end else begin
          sidx_nxt  = sidx_r + SA_W'(1);
          state_nxt = bba_pkg::S_SCAN_RD;
        end
      end

      bba_pkg::S_ARD: begin
        m_re      = 1'b1;
        base_nxt  = BASE_W'(word_r) * BASE_W'(MAP_WORD_BITS);
        state_nxt = bba_pkg::S_AFIND;
      end

      bba_pkg::S_AFIND: begin
        bpos_nxt  = mz_idx;
        state_nxt = bba_pkg::S_AWR;
      end

      bba_pkg::S_AWR: begin
        if (b_c >= CW'(size.managed)) begin
          st_nxt = bba_pkg::ST_NOSPACE;
        end else begin
          m_we     = 1'b1;
          m_wdata  = m_set;
          s_we     = (m_set == M_ONES);
          s_waddr  = sidx_r;
          s_wdata  = s_rdata | s_bit;
          free_nxt = free_r - CNT_W'(1);
          gr_nxt   = BLK_W'(b_c);
          bit_nxt  = 1'b1;
        end
        state_nxt = bba_pkg::S_DONE;
      end

      bba_pkg::S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) state_nxt = bba_pkg::S_IDLE;
      end

      default: state_nxt = bba_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bba_pkg::S_INIT;
      clr_r   <= 1'b1;
      wcnt_r  <= '0;
      base_r  <= '0;
      rinit_r <= '0;
      sacc_r  <= S_ONES;
      sidx_r  <= '0;
      free_r  <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      wcnt_r  <= wcnt_nxt;
      base_r  <= base_nxt;
      rinit_r <= rinit_nxt;
      sacc_r  <= sacc_nxt;
      sidx_r  <= sidx_nxt;
      free_r  <= free_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fn_r   <= fn_nxt;
    blk_r  <= blk_nxt;
    word_r <= word_nxt;
    bpos_r <= bpos_nxt;
    prod_r <= prod_nxt;
    gr_r   <= gr_nxt;
    bit_r  <= bit_nxt;
    st_r   <= st_nxt;
  end

  assign res.granted_block = gr_r;
  assign res.bit_value     = bit_r;
  assign res.status        = st_r;
  assign res.free_count    = free_r;

endmodule

// ===== src/bitmap_block_allocator_unit.sv =====
// Bitmap first-fit block allocator.
// Input channel (in_valid/in_ready) carries a function code and a block number:
// init, allocate, free or test. Each transaction yields exactly one result on the
// out_ channel: granted block, map bit after the operation, status, free count.
// Configuration (cfg_valid/cfg_ready, always ready) sets total and reserved blocks;
// write it only while the block is idle.
// The map lives in a word-wide RAM (MAP_WORD_BITS bits per word); a second RAM
// holds one "word full" bit per map word, 32 to a summary word.
// From acceptance to result: free/test divide, read and then modify or test the
// bit; out-of-range goes straight to the result; init writes one map word per
// cycle; allocate scans the summary RAM word by word (2048-bit summary at the defaults).
// Allocate cost is set by the summary RAM scan; init by the map RAM write port.
// After reset the map is cleared by the same sweep over all NUM_WORDS words (2048 at
// the defaults), while in_ready stays low; the free count resets to zero.
// A finished result waits in the output register; if the receiver stalls, the
// next transaction may be accepted and held finished until the register drains.
module bitmap_block_allocator_unit #(
  parameter int MAX_BLOCKS    = 65536,
  parameter int MAP_WORD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_func,
  input  logic [bba_pkg::BLK_W-1:0]     in_block_number,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bba_pkg::BLK_W-1:0]     out_granted_block,
  output logic                          out_bit_value,
  output logic [1:0]                    out_status,
  output logic [bba_pkg::CNT_W-1:0]     out_free_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bba_pkg::CNT_W-1:0]     cfg_data
);

  localparam int CNT_W = bba_pkg::CNT_W;
  localparam int CAP   = (MAX_BLOCKS < bba_pkg::FIELD_CAP) ? MAX_BLOCKS : bba_pkg::FIELD_CAP;
  localparam logic [CNT_W-1:0] CAP_V = CNT_W'(CAP);

  logic [CNT_W-1:0] total_r, reserved_r;
  logic [CNT_W-1:0] managed;
  bba_pkg::size_t   size;
  bba_pkg::res_t    res, out_res_r;
  logic             res_valid, res_ready;
  logic             out_valid_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r    <= CNT_W'(bba_pkg::FIELD_CAP);
      reserved_r <= '0;
    end else if (cfg_valid) begin
      case (bba_pkg::cfg_reg_t'(cfg_index))
        bba_pkg::REG_TOTAL:    total_r    <= cfg_data;
        bba_pkg::REG_RESERVED: reserved_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign managed       = (total_r > CAP_V) ? CAP_V : total_r;
  assign size.managed  = managed;
  assign size.reserved = (reserved_r > managed) ? managed : reserved_r;

  bba_ctrl #(.MAX_BLOCKS(MAX_BLOCKS), .MAP_WORD_BITS(MAP_WORD_BITS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_func),
    .in_block  (in_block_number),
    .size      (size),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) out_res_r <= res;
  end

  assign out_valid         = out_valid_r;
  assign out_granted_block = out_res_r.granted_block;
  assign out_bit_value     = out_res_r.bit_value;
  assign out_status        = out_res_r.status;
  assign out_free_count    = out_res_r.free_count;

endmodule

// ===== src/bba_checker.sv =====
`include "assert_macros.svh"

module bba_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [bba_pkg::BLK_W-1:0] out_granted_block,
  input logic                      out_bit_value,
  input logic [1:0]                out_status,
  input logic [bba_pkg::CNT_W-1:0] out_free_count
);

  `BBA_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_granted_block) && $stable(out_bit_value) && $stable(out_status) && $stable(out_free_count), "stalled result changed")
  `BBA_ASSERT(a_nospace, clk, rst_n, out_valid && out_status == bba_pkg::ST_NOSPACE |-> out_granted_block == '0 && !out_bit_value, "no-space result not zeroed")
  `BBA_ASSERT(a_range, clk, rst_n, out_valid && out_status == bba_pkg::ST_RANGE |-> !out_bit_value, "out-of-range result shows a set bit")
  `BBA_ASSERT_NR(a_reset, clk, !rst_n |=> !out_valid && !in_ready, "block active right after reset")

endmodule

bind bitmap_block_allocator_unit bba_checker u_bba_checker (.*);
